### rtl/core/rqeb_pkg.sv
// shared types and codes for the retry queue with exponential backoff
package rqeb_pkg;

   // action codes
   localparam logic [2:0] ACT_PUSH     = 3'd0;
   localparam logic [2:0] ACT_POP      = 3'd1;
   localparam logic [2:0] ACT_POLL     = 3'd2;
   localparam logic [2:0] ACT_ACK_HEAD = 3'd3;
   localparam logic [2:0] ACT_ACK_SEQ  = 3'd4;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_EMPTY     = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_TOO_LARGE = 3'd3;
   localparam logic [2:0] ST_NOT_DUE   = 3'd4;
   localparam logic [2:0] ST_MISMATCH  = 3'd5;

   // register indexes
   localparam logic REG_CAPACITY = 1'b0;
   localparam logic REG_INTERVAL = 1'b1;

   localparam logic [4:0]  CAPACITY_RESET = 5'd16;
   localparam logic [31:0] INTERVAL_RESET = 32'd1000;
   localparam logic [7:0]  RETRY_MAX      = 8'd255;

   // one transmit descriptor
   typedef struct packed {
      logic [31:0] sequence_id;
      logic [47:0] destination;
      logic [15:0] handle;
      logic [11:0] length;
   } desc_type;

   // commands to the head timer
   typedef struct packed {
      logic first_poll;
      logic retry_poll;
      logic drop;
   } head_cmd_type;

   // head timing state seen by the control logic
   typedef struct packed {
      logic        attempted;
      logic        due;
      logic [7:0]  retries;
      logic [7:0]  retries_next;
      logic [31:0] first_ms;
      logic [31:0] last_ms;
   } head_state_type;

endpackage

### rtl/core/rqeb_cell.sv
// one queue cell: holds a descriptor, takes its neighbour's on a shift
module rqeb_cell (
   input  logic              clock,
   input  logic              shift_en,
   input  logic              load_en,
   input  rqeb_pkg::desc_type load_data,
   input  rqeb_pkg::desc_type next_data,
   output rqeb_pkg::desc_type data_q
);

   rqeb_pkg::desc_type data_ff;
   rqeb_pkg::desc_type data_in;

   always_comb begin
      data_in = data_ff;
      if (shift_en) begin
         data_in = next_data;
      end else if (load_en) begin
         data_in = load_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_q = data_ff;

endmodule

### rtl/core/rqeb_head_timer.sv
// retry count, attempt times and due check for the head descriptor
module rqeb_head_timer #(
   parameter int BACKOFF_SHIFT_CAP = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  rqeb_pkg::head_cmd_type  cmd,
   input  logic [31:0]             now_ms,
   input  logic [31:0]             interval_ms,
   output rqeb_pkg::head_state_type state
);

   logic        attempted_ff, attempted_in;
   logic [7:0]  retries_ff, retries_in;
   logic [31:0] first_ff, first_in;
   logic [31:0] last_ff, last_in;

   logic [7:0]  shift_sel;
   logic [31:0] wait_ms;
   logic [31:0] elapsed_ms;
   logic [7:0]  retries_inc;

   always_comb begin
      shift_sel   = (retries_ff > 8'(BACKOFF_SHIFT_CAP)) ? 8'(BACKOFF_SHIFT_CAP) : retries_ff;
      wait_ms     = interval_ms << shift_sel[4:0];
      elapsed_ms  = now_ms - last_ff;
      retries_inc = (retries_ff < rqeb_pkg::RETRY_MAX) ? retries_ff + 8'd1 : retries_ff;
   end

   always_comb begin
      attempted_in = attempted_ff;
      retries_in   = retries_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      if (cmd.drop) begin
         attempted_in = 1'b0;
         retries_in   = 8'd0;
         first_in     = 32'd0;
         last_in      = 32'd0;
      end else if (cmd.first_poll) begin
         attempted_in = 1'b1;
         first_in     = now_ms;
         last_in      = now_ms;
      end else if (cmd.retry_poll) begin
         retries_in   = retries_inc;
         last_in      = now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attempted_ff <= 1'b0;
         retries_ff   <= 8'd0;
         first_ff     <= 32'd0;
         last_ff      <= 32'd0;
      end else begin
         attempted_ff <= attempted_in;
         retries_ff   <= retries_in;
         first_ff     <= first_in;
         last_ff      <= last_in;
      end
   end

   assign state.attempted    = attempted_ff;
   assign state.due          = (elapsed_ms >= wait_ms);
   assign state.retries      = retries_ff;
   assign state.retries_next = retries_inc;
   assign state.first_ms     = first_ff;
   assign state.last_ms      = last_ff;

endmodule

### rtl/core/retry_queue_exponential_backoff_top.sv
// top level of the retry queue with exponential backoff
// the result of an accepted item is registered and presented on rsp_ in the cycle after its transfer
// throughput: one item per cycle; req_ready drops only while a result waits in the output register
// the head decision (one 32-bit subtract and compare against the shifted interval) is combinational
// reset: occupancy, head timing and the output valid flag clear at once, registers take their
// reset values; descriptor cells and output data are not cleared and no clearing pass runs
module retry_queue_exponential_backoff_top #(
   parameter int DEPTH             = 16,
   parameter int MAX_PAYLOAD_BYTES = 2048,
   parameter int BACKOFF_SHIFT_CAP = 5
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_action,
   input  logic [31:0] req_now_ms,
   input  logic [31:0] req_sequence_req,
   input  logic [47:0] req_destination,
   input  logic [15:0] req_payload_handle,
   input  logic [15:0] req_payload_length,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_out_sequence,
   output logic [47:0] rsp_out_destination,
   output logic [15:0] rsp_out_payload_handle,
   output logic [11:0] rsp_out_payload_length,
   output logic [7:0]  rsp_out_retries,
   output logic [31:0] rsp_out_first_attempt_ms,
   output logic [31:0] rsp_out_last_attempt_ms,
   output logic [4:0]  rsp_entry_count,
   // configuration port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int OCC_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (OCC_W > 5) ? OCC_W : 5;

   // configuration registers
   logic [4:0]  capacity_ff, capacity_in;
   logic [31:0] interval_ff, interval_in;
   logic        cfg_write;

   assign pready    = 1'b1;
   assign cfg_write = psel && penable && pwrite;

   always_comb begin
      capacity_in = capacity_ff;
      interval_in = interval_ff;
      if (cfg_write) begin
         case (paddr[2])
            rqeb_pkg::REG_CAPACITY: capacity_in = pwdata[4:0];
            rqeb_pkg::REG_INTERVAL: interval_in = pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         rqeb_pkg::REG_CAPACITY: prdata = {27'd0, capacity_ff};
         rqeb_pkg::REG_INTERVAL: prdata = interval_ff;
         default:                prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= rqeb_pkg::CAPACITY_RESET;
         interval_ff <= rqeb_pkg::INTERVAL_RESET;
      end else begin
         capacity_ff <= capacity_in;
         interval_ff <= interval_in;
      end
   end

   // handshake: a new item is taken whenever the output register is free or draining
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // occupancy count
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic [CMP_W-1:0] occ_ext, cap_ext;
   logic             full, empty;

   assign occ_ext = CMP_W'(occ_ff);
   assign cap_ext = (CMP_W'(capacity_ff) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH)
                                                           : CMP_W'(capacity_ff);
   assign full    = (occ_ext >= cap_ext);
   assign empty   = (occ_ff == '0);

   // the chain of cells, cell 0 is the head
   rqeb_pkg::desc_type cell_data [DEPTH];
   rqeb_pkg::desc_type push_data;
   rqeb_pkg::desc_type head;
   logic               push_ok, drop_ok;

   assign push_data.sequence_id = req_sequence_req;
   assign push_data.destination = req_destination;
   assign push_data.handle      = req_payload_handle;
   assign push_data.length      = req_payload_length[11:0];
   assign head                  = cell_data[0];

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      rqeb_cell u_cell (
         .clock     (clock),
         .shift_en  (accept && drop_ok),
         .load_en   (accept && push_ok && (occ_ff == OCC_W'(i))),
         .load_data (push_data),
         // last cell has no upstream neighbour, it just refills from itself
         .next_data ((i == DEPTH - 1) ? cell_data[i] : cell_data[(i + 1) % DEPTH]),
         .data_q    (cell_data[i])
      );
   end

   // head timing
   rqeb_pkg::head_cmd_type   head_cmd, timer_cmd;
   rqeb_pkg::head_state_type head_state;

   assign timer_cmd.first_poll = accept && head_cmd.first_poll;
   assign timer_cmd.retry_poll = accept && head_cmd.retry_poll;
   assign timer_cmd.drop       = accept && head_cmd.drop;

   rqeb_head_timer #(
      .BACKOFF_SHIFT_CAP (BACKOFF_SHIFT_CAP)
   ) u_head_timer (
      .clock       (clock),
      .reset       (reset),
      .cmd         (timer_cmd),
      .now_ms      (req_now_ms),
      .interval_ms (interval_ff),
      .state       (head_state)
   );

   // action decode and result
   logic [2:0]  res_status;
   logic        res_emit;
   logic [7:0]  res_retries;
   logic [31:0] res_first, res_last;

   always_comb begin
      res_status  = rqeb_pkg::ST_OK;
      res_emit    = 1'b0;
      res_retries = head_state.retries;
      res_first   = head_state.first_ms;
      res_last    = head_state.last_ms;
      push_ok     = 1'b0;
      drop_ok     = 1'b0;
      head_cmd    = '0;
      case (req_action)
         rqeb_pkg::ACT_PUSH: begin
            if (full) begin
               res_status = rqeb_pkg::ST_FULL;
            end else if (req_payload_length > 16'(MAX_PAYLOAD_BYTES)) begin
               res_status = rqeb_pkg::ST_TOO_LARGE;
            end else begin
               push_ok = 1'b1;
            end
         end
         rqeb_pkg::ACT_POP, rqeb_pkg::ACT_ACK_HEAD: begin
            if (empty) begin
               res_status = rqeb_pkg::ST_EMPTY;
            end else begin
               res_emit      = 1'b1;
               drop_ok       = 1'b1;
               head_cmd.drop = 1'b1;
            end
         end
         rqeb_pkg::ACT_POLL: begin
            if (empty) begin
               res_status = rqeb_pkg::ST_EMPTY;
            end else if (!head_state.attempted) begin
               // first poll of a head always goes out and stamps both times
               res_emit            = 1'b1;
               res_first           = req_now_ms;
               res_last            = req_now_ms;
               head_cmd.first_poll = 1'b1;
            end else if (!head_state.due) begin
               res_status = rqeb_pkg::ST_NOT_DUE;
            end else begin
               res_emit            = 1'b1;
               res_retries         = head_state.retries_next;
               res_last            = req_now_ms;
               head_cmd.retry_poll = 1'b1;
            end
         end
         rqeb_pkg::ACT_ACK_SEQ: begin
            if (empty) begin
               res_status = rqeb_pkg::ST_EMPTY;
            end else if (head.sequence_id != req_sequence_req) begin
               res_status = rqeb_pkg::ST_MISMATCH;
            end else begin
               res_emit      = 1'b1;
               drop_ok       = 1'b1;
               head_cmd.drop = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      occ_in = occ_ff;
      if (accept && push_ok) begin
         occ_in = occ_ff + OCC_W'(1);
      end else if (accept && drop_ok) begin
         occ_in = occ_ff - OCC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   // output register
   logic [2:0]  status_ff;
   logic [31:0] seq_ff;
   logic [47:0] dest_ff;
   logic [15:0] handle_ff;
   logic [11:0] length_ff;
   logic [7:0]  retries_ff;
   logic [31:0] first_ff, last_ff;
   logic [4:0]  count_ff;

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff  <= res_status;
         seq_ff     <= res_emit ? head.sequence_id : 32'd0;
         dest_ff    <= res_emit ? head.destination : 48'd0;
         handle_ff  <= res_emit ? head.handle : 16'd0;
         length_ff  <= res_emit ? head.length : 12'd0;
         retries_ff <= res_emit ? res_retries : 8'd0;
         first_ff   <= res_emit ? res_first : 32'd0;
         last_ff    <= res_emit ? res_last : 32'd0;
         count_ff   <= 5'(occ_in);
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_status               = status_ff;
   assign rsp_out_sequence         = seq_ff;
   assign rsp_out_destination      = dest_ff;
   assign rsp_out_payload_handle   = handle_ff;
   assign rsp_out_payload_length   = length_ff;
   assign rsp_out_retries          = retries_ff;
   assign rsp_out_first_attempt_ms = first_ff;
   assign rsp_out_last_attempt_ms  = last_ff;
   assign rsp_entry_count          = count_ff;

   // checks
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(occ_ff) <= CMP_W'(DEPTH))
      else $error("occupancy beyond depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      accept && push_ok |=> occ_ff == $past(occ_ff) + OCC_W'(1))
      else $error("accepted push did not grow the queue");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status == rqeb_pkg::ST_EMPTY) |-> rsp_entry_count == 5'd0)
      else $error("empty status with entries present");

   a_fresh_head: assert property (@(posedge clock) disable iff (reset)
      !head_state.attempted |-> head_state.retries == 8'd0)
      else $error("retries counted on an unattempted head");

   a_one_op: assert property (@(posedge clock) disable iff (reset)
      !(push_ok && drop_ok))
      else $error("push and removal decoded together");

endmodule
